/* hdl/ltpp_pkg.sv */
// ltpp_pkg: constants, register indexes and the servo 3 target table
// for the learned torque profile player; no dependencies
package ltpp_pkg;

  localparam int POS_W   = 13;
  localparam int LOAD_W  = 12;
  localparam int ERR_W   = 14;
  localparam int STEP_W  = 7;
  localparam int PHASE_W = 2;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 13;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_STEPS_IN_USE    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ADAPT_STOP_STEP = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ERROR_LIMIT     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ADAPT_STEP      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RETURN_LOAD     = 3'd4;

  // phase codes on the result word
  localparam logic [PHASE_W-1:0] PH_RETURNING   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_RETURN_DONE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_PLAYING     = 2'd2;
  localparam logic [PHASE_W-1:0] PH_PLAY_DONE   = 2'd3;

  // fixed positions and loads
  localparam logic [POS_W-1:0]  HOME_POS_12 = 13'd2880;
  localparam logic [POS_W-1:0]  HOME_POS_3  = 13'd800;
  localparam logic [POS_W-1:0]  PLAY_POS_3  = 13'd4800;
  localparam logic [POS_W-1:0]  ROM_TAIL    = 13'd4720;
  localparam logic [LOAD_W-1:0] LOAD_MAX    = 12'd4095;
  localparam logic [LOAD_W-1:0] LOAD_INIT   = 12'd200;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [LOAD_W-1:0] load_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // servo 3 play target: 16*(50 + 245/(1+exp(10-0.3n))), rounded
  function automatic pos_t sig_target(input logic [STEP_W-1:0] n);
    pos_t t;
    if (n[6]) begin
      t = ROM_TAIL;
    end else begin
      case (n[5:0])
        6'd0:  t = 13'd800;   6'd1:  t = 13'd800;   6'd2:  t = 13'd800;
        6'd3:  t = 13'd800;   6'd4:  t = 13'd801;   6'd5:  t = 13'd801;
        6'd6:  t = 13'd801;   6'd7:  t = 13'd801;   6'd8:  t = 13'd802;
        6'd9:  t = 13'd803;   6'd10: t = 13'd804;   6'd11: t = 13'd805;
        6'd12: t = 13'd807;   6'd13: t = 13'd809;   6'd14: t = 13'd812;
        6'd15: t = 13'd816;   6'd16: t = 13'd822;   6'd17: t = 13'd829;
        6'd18: t = 13'd839;   6'd19: t = 13'd852;   6'd20: t = 13'd871;
        6'd21: t = 13'd895;   6'd22: t = 13'd927;   6'd23: t = 13'd969;
        6'd24: t = 13'd1025;  6'd25: t = 13'd1097;  6'd26: t = 13'd1191;
        6'd27: t = 13'd1310;  6'd28: t = 13'd1458;  6'd29: t = 13'd1640;
        6'd30: t = 13'd1854;  6'd31: t = 13'd2101;  6'd32: t = 13'd2373;
        6'd33: t = 13'd2662;  6'd34: t = 13'd2955;  6'd35: t = 13'd3240;
        6'd36: t = 13'd3505;  6'd37: t = 13'd3741;  6'd38: t = 13'd3945;
        6'd39: t = 13'd4114;  6'd40: t = 13'd4253;  6'd41: t = 13'd4363;
        6'd42: t = 13'd4449;  6'd43: t = 13'd4516;  6'd44: t = 13'd4566;
        6'd45: t = 13'd4605;  6'd46: t = 13'd4634;  6'd47: t = 13'd4656;
        6'd48: t = 13'd4672;  6'd49: t = 13'd4685;  6'd50: t = 13'd4694;
        6'd51: t = 13'd4701;  6'd52: t = 13'd4706;  6'd53: t = 13'd4709;
        6'd54: t = 13'd4712;  6'd55: t = 13'd4714;  6'd56: t = 13'd4716;
        6'd57: t = 13'd4717;  6'd58: t = 13'd4718;  6'd59: t = 13'd4718;
        default: t = 13'd4719;
      endcase
    end
    return t;
  endfunction

  // move a load up or down by amount, saturating at 0 and LOAD_MAX
  function automatic load_t sat_move(input load_t v, input logic up,
                                     input logic [9:0] amount);
    logic [LOAD_W:0] sum;
    load_t r;
    sum = {1'b0, v} + {3'b000, amount};
    if (up) begin
      r = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
    end else begin
      r = (v < {2'b00, amount}) ? '0 : v - {2'b00, amount};
    end
    return r;
  endfunction

endpackage

/* hdl/learned_torque_profile_player_top.sv */
// learned_torque_profile_player_top: return/play sequencer with a learned
// per-step load table adapted on servo 3 error; depends on ltpp_pkg
//
//  channel | dir | handshake          | content
//  in_     | in  | tvalid/tready      | three measured positions
//  out_    | out | tvalid/tready      | commands, loads, errors; phase in tuser
//  cfg_    | in  | cfg_we             | register index and write data
//
// one word per cycle: a word is taken whenever the result register is empty
// or being emptied in the same cycle; the result is registered at accept
// the phase, step counter, load table and held outputs all update at accept
// and the held outputs are the result register itself
// a stall on out_ stops in_ until the waiting word is taken
// reset (rst_n low, synchronous) loads all table entries with 200 at once
module learned_torque_profile_player_top
  import ltpp_pkg::*;
#(
  parameter int MAX_STEPS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // measured_pos_1 [12:0], measured_pos_2 [25:13], measured_pos_3 [38:26]
  input  logic [39:0]         in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // cmd_pos_1..3 [38:0], load_1..3 [74:39], error_1..3 [116:75]
  output logic [119:0]        out_tdata,
  // phase_code [1:0]
  output logic [PHASE_W-1:0]  out_tuser,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata
);

  localparam logic [8:0] MAX_N = 9'(MAX_STEPS);

  // configuration registers
  logic [STEP_W-1:0] steps_r, stop_r;
  logic [12:0]       limit_r;
  logic [9:0]        adapt_r;
  load_t             ret_load_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r    <= 7'd50;
      stop_r     <= 7'd50;
      limit_r    <= 13'd160;
      adapt_r    <= 10'd20;
      ret_load_r <= 12'd1000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STEPS_IN_USE:    steps_r    <= cfg_wdata[STEP_W-1:0];
        REG_ADAPT_STOP_STEP: stop_r     <= cfg_wdata[STEP_W-1:0];
        REG_ERROR_LIMIT:     limit_r    <= cfg_wdata;
        REG_ADAPT_STEP:      adapt_r    <= cfg_wdata[9:0];
        REG_RETURN_LOAD:     ret_load_r <= cfg_wdata[LOAD_W-1:0];
        default: ;
      endcase
    end
  end

  // state
  logic              returning_r, returning_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  load_t             tbl_r [MAX_STEPS];
  load_t             tbl_nxt [MAX_STEPS];
  pos_t              cmd_r [3];
  pos_t              cmd_nxt [3];
  load_t             load_r [3];
  load_t             load_nxt [3];
  err_t              err_r [3];
  err_t              err_nxt [3];
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic              valid_r;

  logic acc;
  assign in_tready = !valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  // input fields
  pos_t meas1, meas2, meas3;
  assign meas1 = in_tdata[12:0];
  assign meas2 = in_tdata[25:13];
  assign meas3 = in_tdata[38:26];

  // effective step count and phase test
  logic [8:0] n_eff;
  logic       in_phase;
  assign n_eff    = ({2'b00, steps_r} > MAX_N) ? MAX_N : {2'b00, steps_r};
  assign in_phase = {2'b00, step_r} < n_eff;

  // table read at the current step
  load_t tbl_rd;
  always_comb begin
    tbl_rd = '0;
    for (int i = 0; i < MAX_STEPS; i++) begin
      if ({1'b0, step_r} == 8'(i)) tbl_rd = tbl_r[i];
    end
  end

  // errors and adaptation decision
  err_t  e1, e2, e3;
  logic  up;
  logic [ERR_W-1:0] mag;
  logic  adapt_en, half_en;
  logic [7:0] sm1, sm2;
  assign e1  = $signed({1'b0, HOME_POS_12}) - $signed({1'b0, meas1});
  assign e2  = $signed({1'b0, HOME_POS_12}) - $signed({1'b0, meas2});
  assign e3  = $signed({1'b0, sig_target(step_r)}) - $signed({1'b0, meas3});
  assign up  = e3 > 0;
  assign mag = up ? e3 : -e3;
  assign adapt_en = !returning_r && in_phase && (mag > {1'b0, limit_r})
                    && (step_r != '0) && (step_r < stop_r);
  assign half_en  = step_r > 7'd1;
  assign sm1 = {1'b0, step_r} - 8'd1;
  assign sm2 = {1'b0, step_r} - 8'd2;

  // load table update: previous step full amount, the one before half
  always_comb begin
    for (int i = 0; i < MAX_STEPS; i++) begin
      tbl_nxt[i] = tbl_r[i];
      if (adapt_en && sm1 == 8'(i)) begin
        tbl_nxt[i] = sat_move(tbl_r[i], up, adapt_r);
      end else if (adapt_en && half_en && sm2 == 8'(i)) begin
        tbl_nxt[i] = sat_move(tbl_r[i], up, {1'b0, adapt_r[9:1]});
      end
    end
  end

  // sequencer and held outputs
  always_comb begin
    returning_nxt = returning_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    load_nxt      = load_r;
    err_nxt       = err_r;
    if (returning_r) begin
      if (in_phase) begin
        cmd_nxt  = '{HOME_POS_12, HOME_POS_12, HOME_POS_3};
        load_nxt = '{ret_load_r, ret_load_r, ret_load_r};
        step_nxt = step_r + 7'd1;
        phase_nxt = PH_RETURNING;
      end else begin
        step_nxt      = '0;
        returning_nxt = 1'b0;
        phase_nxt     = PH_RETURN_DONE;
      end
    end else if (in_phase) begin
      cmd_nxt  = '{HOME_POS_12, HOME_POS_12, PLAY_POS_3};
      load_nxt = '{tbl_rd, tbl_rd, tbl_rd};
      err_nxt  = '{e1, e2, e3};
      step_nxt = step_r + 7'd1;
      phase_nxt = PH_PLAYING;
    end else begin
      step_nxt      = '0;
      returning_nxt = 1'b1;
      phase_nxt     = PH_PLAY_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      returning_r <= 1'b1;
      step_r      <= '0;
      phase_r     <= PH_RETURNING;
      valid_r     <= 1'b0;
      for (int i = 0; i < MAX_STEPS; i++) tbl_r[i] <= LOAD_INIT;
      for (int k = 0; k < 3; k++) begin
        cmd_r[k]  <= '0;
        load_r[k] <= '0;
        err_r[k]  <= '0;
      end
    end else begin
      if (acc) begin
        returning_r <= returning_nxt;
        step_r      <= step_nxt;
        phase_r     <= phase_nxt;
        tbl_r       <= tbl_nxt;
        cmd_r       <= cmd_nxt;
        load_r      <= load_nxt;
        err_r       <= err_nxt;
      end
      if (acc) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // result word
  assign out_tvalid = valid_r;
  assign out_tuser  = phase_r;
  assign out_tdata  = {3'b000, err_r[2], err_r[1], err_r[0],
                       load_r[2], load_r[1], load_r[0],
                       cmd_r[2], cmd_r[1], cmd_r[0]};

  // a phase end always clears the step counter
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_phase |=> step_r == '0)
    else $error("step counter not cleared at phase end");

  // return ticks drive return_load on every servo (checked on servos 1 and 3)
  a_return_load: assert property (@(posedge clk) disable iff (!rst_n)
    acc && returning_r && in_phase |=>
      load_r[0] == $past(ret_load_r) && load_r[2] == $past(ret_load_r))
    else $error("return load not applied");

  // play ticks report playing with equal loads
  a_play_load: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !returning_r && in_phase |=>
      out_tuser == PH_PLAYING && load_r[0] == load_r[2])
    else $error("play tick result wrong");

  // input only stalls while a result waits
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty result register");

endmodule
